/* rtl/ppdr_pkg.sv */
// ----------------------------------------------------------------------------
// ppdr_pkg
// Shared widths, particle codes, angle formats and entry types of the
// particle pair delta-R block.
// ----------------------------------------------------------------------------
package ppdr_pkg;

	// Stored angle width (signed, 11 fraction bits); valid from 12 to 32
	localparam int ANGLE_W = 16;

	// Field widths of the words on the ports
	localparam int PID_W = 24;
	localparam int ETA_W = 16;
	localparam int PHI_W = 14;
	localparam int DR_W  = 16;

	// Sign-extension width before wrapping an angle to ANGLE_W bits
	localparam int EXT_W = (ANGLE_W > ETA_W) ? ANGLE_W : ETA_W;

	// Width of angle differences and the phi wrap arithmetic
	localparam int DIFF_W = ANGLE_W + 4;

	// Particle type codes
	localparam logic signed [PID_W-1:0] PID_HIGGS = PID_W'(25);
	localparam logic signed [PID_W-1:0] PID_A0    = PID_W'(28);
	localparam logic signed [PID_W-1:0] PID_B     = PID_W'(5);
	localparam logic signed [PID_W-1:0] PID_ANTIB = -PID_W'(5);

	// pi and two pi in Q.11
	localparam int PI_Q11     = 6434;
	localparam int TWO_PI_Q11 = 2 * PI_Q11;

	// Saturation level of a delta-R result
	localparam logic [DR_W-1:0] DR_MAX = {DR_W{1'b1}};

	// Square root unit: radicand holds the sum of two DR_W-bit squares
	localparam int RAD_W  = 2 * DR_W + 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 3;
	localparam int ITER_W = $clog2(ROOT_W);

	// Event queue between front and back
	localparam int FIFO_DEPTH = 2;

	typedef logic signed [ANGLE_W-1:0] angle_t;

	typedef struct packed {
		angle_t eta;
		angle_t phi;
	} point_t;

	// Snapshot of all stored particles at an event end
	typedef struct packed {
		point_t higgs;
		point_t a0;
		point_t b;
		point_t antib;
	} snap_t;

	// Wrap a sign-extended angle to the stored width
	function automatic angle_t to_angle(input logic signed [EXT_W-1:0] x);
		return ANGLE_W'(x);
	endfunction

endpackage

/* rtl/ppdr_front.sv */
// ----------------------------------------------------------------------------
// ppdr_front
// Accepts particle words, keeps the last eta and phi of each tracked kind and
// pushes a snapshot of all four kinds into the event queue on an event end.
// ----------------------------------------------------------------------------
module ppdr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ppdr_pkg::PID_W-1:0]   pid,
	input  logic signed [ppdr_pkg::ETA_W-1:0]   eta,
	input  logic signed [ppdr_pkg::PHI_W-1:0]   phi,
	input  logic                                last_in_event,
	output logic                                wr_en,
	output ppdr_pkg::snap_t                     wr_data,
	input  logic                                full
);

	ppdr_pkg::snap_t  store_q;
	ppdr_pkg::snap_t  store_nx;
	ppdr_pkg::point_t pt;
	logic             accept;

	// Hold only words that would push into a full queue
	assign in_ready = !full || !last_in_event;
	assign accept   = in_valid && in_ready;

	assign pt.eta = ppdr_pkg::to_angle(ppdr_pkg::EXT_W'(eta));
	assign pt.phi = ppdr_pkg::to_angle(ppdr_pkg::EXT_W'(phi));

	// Classify the word and overwrite the matching kind
	always_comb begin
		store_nx = store_q;
		unique case (pid)
			ppdr_pkg::PID_HIGGS: store_nx.higgs = pt;
			ppdr_pkg::PID_A0:    store_nx.a0    = pt;
			ppdr_pkg::PID_B:     store_nx.b     = pt;
			ppdr_pkg::PID_ANTIB: store_nx.antib = pt;
			default:             store_nx       = store_q;
		endcase
	end

	// Push the updated snapshot at an event end
	assign wr_en   = accept && last_in_event;
	assign wr_data = store_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (accept) begin
			store_q <= store_nx;
		end
	end

endmodule

/* rtl/ppdr_fifo.sv */
// ----------------------------------------------------------------------------
// ppdr_fifo
// Short queue of event snapshots between the front and the back.
// ----------------------------------------------------------------------------
module ppdr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  ppdr_pkg::snap_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output ppdr_pkg::snap_t rd_data,
	output logic            empty
);

	localparam int PTR_W = (ppdr_pkg::FIFO_DEPTH > 1) ? $clog2(ppdr_pkg::FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(ppdr_pkg::FIFO_DEPTH + 1);

	ppdr_pkg::snap_t  mem_q [ppdr_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(ppdr_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ppdr_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ppdr_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("event queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("event queue read while empty");

endmodule

/* rtl/ppdr_back.sv */
// ----------------------------------------------------------------------------
// ppdr_back
// Pops event snapshots and computes delta-R for higgs/a0 and b/anti-b with
// one shared subtract, square and bit-serial square root path.
// ----------------------------------------------------------------------------
module ppdr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	output logic                          rd_en,
	input  ppdr_pkg::snap_t               rd_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ppdr_pkg::DR_W-1:0]     dr_higgs_a0,
	output logic [ppdr_pkg::DR_W-1:0]     dr_b_antib
);

	localparam int DIFF_W = ppdr_pkg::DIFF_W;
	localparam int DR_W   = ppdr_pkg::DR_W;
	localparam int RAD_W  = ppdr_pkg::RAD_W;
	localparam int ROOT_W = ppdr_pkg::ROOT_W;
	localparam int REM_W  = ppdr_pkg::REM_W;
	localparam int ITER_W = ppdr_pkg::ITER_W;

	localparam logic signed [DIFF_W-1:0] PI_D     = DIFF_W'(ppdr_pkg::PI_Q11);
	localparam logic signed [DIFF_W-1:0] TWO_PI_D = DIFF_W'(ppdr_pkg::TWO_PI_Q11);
	localparam logic [DIFF_W-1:0]        MAG_MAX  = DIFF_W'(ppdr_pkg::DR_MAX);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_ABS,
		S_SQ,
		S_SUM,
		S_ROOT,
		S_STORE
	} state_t;

	state_t                    state_q;
	ppdr_pkg::snap_t           ent_q;
	logic                      pair_q;
	logic signed [DIFF_W-1:0]  de_q;
	logic signed [DIFF_W-1:0]  dp_q;
	logic [DR_W-1:0]           ue_q;
	logic [DR_W-1:0]           up_q;
	logic                      sat_q;
	logic [2*DR_W-1:0]         sq_e_q;
	logic [2*DR_W-1:0]         sq_p_q;
	logic [RAD_W-1:0]          rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [ITER_W-1:0]         iter_q;
	logic [DR_W-1:0]           res0_q;
	logic                      out_valid_q;
	logic [DR_W-1:0]           dr_ha_q;
	logic [DR_W-1:0]           dr_bb_q;

	ppdr_pkg::point_t          pa;
	ppdr_pkg::point_t          pb;
	logic signed [DIFF_W-1:0]  dp_wrap;
	logic [DIFF_W-1:0]         mag_e;
	logic [DIFF_W-1:0]         mag_p;
	logic [REM_W-1:0]          rem_sh;
	logic [REM_W-1:0]          trial;
	logic [DR_W-1:0]           dr_c;
	logic                      load_out;

	assign rd_en       = (state_q == S_IDLE) && !empty;
	assign out_valid   = out_valid_q;
	assign dr_higgs_a0 = dr_ha_q;
	assign dr_b_antib  = dr_bb_q;

	// Load the output register when the second pair is done and it frees
	assign load_out = (state_q == S_STORE) && pair_q && (!out_valid_q || out_ready);

	// Select the pair under work
	assign pa = pair_q ? ent_q.b     : ent_q.higgs;
	assign pb = pair_q ? ent_q.antib : ent_q.a0;

	// Wrap dphi once and take magnitudes
	always_comb begin
		priority if (dp_q >= PI_D) begin
			dp_wrap = dp_q - TWO_PI_D;
		end else if (dp_q < -PI_D) begin
			dp_wrap = dp_q + TWO_PI_D;
		end else begin
			dp_wrap = dp_q;
		end
		mag_e = de_q[DIFF_W-1] ? DIFF_W'(-de_q) : DIFF_W'(de_q);
		mag_p = dp_wrap[DIFF_W-1] ? DIFF_W'(-dp_wrap) : DIFF_W'(dp_wrap);
	end

	// One root bit per cycle
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});

	// Saturate the finished root
	assign dr_c = (sat_q || (root_q[ROOT_W-1:DR_W] != '0)) ? ppdr_pkg::DR_MAX
	                                                        : root_q[DR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pair_q      <= 1'b0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						ent_q   <= rd_data;
						pair_q  <= 1'b0;
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					de_q    <= DIFF_W'($signed(pa.eta)) - DIFF_W'($signed(pb.eta));
					dp_q    <= DIFF_W'($signed(pa.phi)) - DIFF_W'($signed(pb.phi));
					state_q <= S_ABS;
				end
				S_ABS: begin
					ue_q    <= mag_e[DR_W-1:0];
					up_q    <= mag_p[DR_W-1:0];
					sat_q   <= (mag_e > MAG_MAX) || (mag_p > MAG_MAX);
					state_q <= S_SQ;
				end
				S_SQ: begin
					sq_e_q  <= ue_q * ue_q;
					sq_p_q  <= up_q * up_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					rad_q   <= RAD_W'(sq_e_q) + RAD_W'(sq_p_q);
					rem_q   <= '0;
					root_q  <= '0;
					iter_q  <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					rad_q <= {rad_q[RAD_W-3:0], 2'b00};
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(ROOT_W - 1)) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (!pair_q) begin
						res0_q  <= dr_c;
						pair_q  <= 1'b1;
						state_q <= S_DIFF;
					end else if (load_out) begin
						dr_ha_q     <= res0_q;
						dr_bb_q     <= dr_c;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT) |-> (iter_q <= ITER_W'(ROOT_W - 1)))
		else $error("root iteration count out of range");

	a_pop_starts_pair0: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (state_q == S_DIFF) && !pair_q)
		else $error("popped entry did not start with the first pair");

	a_result_after_pair1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_STORE) && $past(pair_q))
		else $error("result presented before the second pair finished");

endmodule

/* rtl/particle_pair_delta_r_top.sv */
// ----------------------------------------------------------------------------
// particle_pair_delta_r_top
// Delta-R between stored higgs/a0 and b/anti-b particles at each event end.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one particle word per cycle while
// in_ready is high: pid, eta, phi (Q.11) and last_in_event. Words of kind
// 25, 28, 5 and -5 overwrite the stored eta/phi of that kind; other ids are
// dropped. Stored values persist across events.
// Output channel (out_valid/out_ready): one word per event end carrying
// dr_higgs_a0 and dr_b_antib (Q.11, saturated at 65535), computed from the
// stored values including the event-ending particle.
// Throughput: words without an event end are taken every cycle. For each event
// end the back end pops one snapshot and works its two pairs one after the
// other, each through difference, magnitude, square, sum, the 17-step
// bit-serial square root and store; it pops the next snapshot only when idle.
// A two-entry event queue separates front and back; when it is full, an
// event-ending word is held off while other words still pass.
// When the receiver stalls, the result stays in the output register and the
// back end holds its next finished result until the register frees.
// Reset clears all stored angles to zero and empties the queue.
// ----------------------------------------------------------------------------
module particle_pair_delta_r_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [ppdr_pkg::PID_W-1:0]  pid,
	input  logic signed [ppdr_pkg::ETA_W-1:0]  eta,
	input  logic signed [ppdr_pkg::PHI_W-1:0]  phi,
	input  logic                               last_in_event,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ppdr_pkg::DR_W-1:0]          dr_higgs_a0,
	output logic [ppdr_pkg::DR_W-1:0]          dr_b_antib
);

	logic            wr_en;
	ppdr_pkg::snap_t wr_data;
	logic            full;
	logic            rd_en;
	ppdr_pkg::snap_t rd_data;
	logic            empty;

	// Classify and store particles
	ppdr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pid           (pid),
		.eta           (eta),
		.phi           (phi),
		.last_in_event (last_in_event),
		.wr_en         (wr_en),
		.wr_data       (wr_data),
		.full          (full)
	);

	// Queue event snapshots
	ppdr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.empty   (empty)
	);

	// Compute delta-R pairs
	ppdr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.rd_en       (rd_en),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dr_higgs_a0 (dr_higgs_a0),
		.dr_b_antib  (dr_b_antib)
	);

endmodule

/* test/tb_particle_pair_delta_r_top.sv */
// ----------------------------------------------------------------------------
// tb_particle_pair_delta_r_top
// Self-checking bench for the particle pair delta-R block: a queue-fed driver
// sends particle words with random gaps, and a scoreboard tracks the stored
// higgs, a0, b and anti-b angles. It predicts both delta-R values at each
// event end. A monitor with random back-pressure compares every result word
// in order.
// ----------------------------------------------------------------------------
module tb_particle_pair_delta_r_top;

	typedef struct {
		logic signed [ppdr_pkg::PID_W-1:0] pid;
		logic signed [ppdr_pkg::ETA_W-1:0] eta;
		logic signed [ppdr_pkg::PHI_W-1:0] phi;
		logic                              last;
		int unsigned                       gap;
		bit                                drain;
	} particle_word_t;

	typedef struct {
		logic [ppdr_pkg::DR_W-1:0] higgs_a0;
		logic [ppdr_pkg::DR_W-1:0] b_antib;
	} dr_pair_t;

	localparam int N_RANDOM   = 1750;
	localparam int TAIL_WAIT  = 80;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [ppdr_pkg::PID_W-1:0] pid = '0;
	logic signed [ppdr_pkg::ETA_W-1:0] eta = '0;
	logic signed [ppdr_pkg::PHI_W-1:0] phi = '0;
	logic                              last_in_event = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [ppdr_pkg::DR_W-1:0]         dr_higgs_a0;
	logic [ppdr_pkg::DR_W-1:0]         dr_b_antib;

	particle_word_t pending_words[$];
	dr_pair_t       expected_dr[$];
	int             errors = 0;

	// Scoreboard copy of the stored particle angles
	ppdr_pkg::angle_t higgs_eta_q = '0, higgs_phi_q = '0, a0_eta_q = '0, a0_phi_q = '0;
	ppdr_pkg::angle_t b_eta_q = '0, b_phi_q = '0, antib_eta_q = '0, antib_phi_q = '0;

	particle_word_t   next_word;
	dr_pair_t         got_dr;
	dr_pair_t         want_dr;
	dr_pair_t         pred_dr;
	int unsigned      gap_left = 0;
	int unsigned      stall_left = 0;
	int unsigned      stall_draw = 0;
	int unsigned      results_seen = 0;
	bit               rcv_fast = 1'b0;
	ppdr_pkg::angle_t new_eta;
	ppdr_pkg::angle_t new_phi;

	particle_pair_delta_r_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pid          (pid),
		.eta          (eta),
		.phi          (phi),
		.last_in_event(last_in_event),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dr_higgs_a0  (dr_higgs_a0),
		.dr_b_antib   (dr_b_antib)
	);

	always #5 clk = ~clk;

	// Delta-R of two points in Q.11, phi difference wrapped once, saturated
	function automatic logic [ppdr_pkg::DR_W-1:0] dr_q11(ppdr_pkg::angle_t ae,
		ppdr_pkg::angle_t ap, ppdr_pkg::angle_t be, ppdr_pkg::angle_t bp);
		longint          de;
		longint          dp;
		longint unsigned ue;
		longint unsigned up;
		longint unsigned radicand;
		longint unsigned root;
		longint unsigned trial;
		de = longint'(ae) - longint'(be);
		dp = longint'(ap) - longint'(bp);
		if (dp >= ppdr_pkg::PI_Q11)
			dp = dp - ppdr_pkg::TWO_PI_Q11;
		else if (dp < -ppdr_pkg::PI_Q11)
			dp = dp + ppdr_pkg::TWO_PI_Q11;
		ue = (de < 0) ? -de : de;
		up = (dp < 0) ? -dp : dp;
		if (ue > 65535 || up > 65535)
			return ppdr_pkg::DR_MAX;
		radicand = ue * ue + up * up;
		// floor square root, one bit at a time from the top
		root = 0;
		for (int k = 24; k >= 0; k--) begin
			trial = root | (64'd1 << k);
			if (trial * trial <= radicand)
				root = trial;
		end
		return (root > 65535) ? ppdr_pkg::DR_MAX : root[ppdr_pkg::DR_W-1:0];
	endfunction

	// Queue one particle word for the driver
	function automatic void add_word(longint p, longint e, longint f, bit l,
		int unsigned g, bit d = 1'b0);
		particle_word_t w;
		w.pid   = ppdr_pkg::PID_W'(p);
		w.eta   = ppdr_pkg::ETA_W'(e);
		w.phi   = ppdr_pkg::PHI_W'(f);
		w.last  = l;
		w.gap   = g;
		w.drain = d;
		pending_words.push_back(w);
	endfunction

	// Driver: present queued words, record accepted ones in the scoreboard
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			pid           <= '0;
			eta           <= '0;
			phi           <= '0;
			last_in_event <= 1'b0;
			gap_left      <= 0;
		end else begin
			if (in_valid && in_ready) begin
				// store the angles wrapped to the stored width
				new_eta = ppdr_pkg::ANGLE_W'(longint'(eta));
				new_phi = ppdr_pkg::ANGLE_W'(longint'(phi));
				if (pid == ppdr_pkg::PID_HIGGS) begin
					higgs_eta_q = new_eta;
					higgs_phi_q = new_phi;
				end else if (pid == ppdr_pkg::PID_A0) begin
					a0_eta_q = new_eta;
					a0_phi_q = new_phi;
				end else if (pid == ppdr_pkg::PID_B) begin
					b_eta_q = new_eta;
					b_phi_q = new_phi;
				end else if (pid == ppdr_pkg::PID_ANTIB) begin
					antib_eta_q = new_eta;
					antib_phi_q = new_phi;
				end
				if (last_in_event) begin
					pred_dr.higgs_a0 = dr_q11(higgs_eta_q, higgs_phi_q, a0_eta_q, a0_phi_q);
					pred_dr.b_antib  = dr_q11(b_eta_q, b_phi_q, antib_eta_q, antib_phi_q);
					expected_dr.push_back(pred_dr);
				end
			end
			// advance only when the current word is gone
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 &&
					!(pending_words[0].drain && expected_dr.size() > 0)) begin
					next_word = pending_words.pop_front();
					in_valid      <= 1'b1;
					pid           <= next_word.pid;
					eta           <= next_word.eta;
					phi           <= next_word.phi;
					last_in_event <= next_word.last;
					gap_left      <= next_word.gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure, compare each result word in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && out_ready) begin
			got_dr.higgs_a0 = dr_higgs_a0;
			got_dr.b_antib  = dr_b_antib;
			if (expected_dr.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual %0d %0d", $time,
					got_dr.higgs_a0, got_dr.b_antib);
			end else begin
				want_dr = expected_dr.pop_front();
				if (got_dr.higgs_a0 !== want_dr.higgs_a0) begin
					errors++;
					$display("%0t dr_higgs_a0: expected %0d, actual %0d", $time,
						want_dr.higgs_a0, got_dr.higgs_a0);
				end
				if (got_dr.b_antib !== want_dr.b_antib) begin
					errors++;
					$display("%0t dr_b_antib: expected %0d, actual %0d", $time,
						want_dr.b_antib, got_dr.b_antib);
				end
			end
			results_seen++;
			if (results_seen % 40 == 0)
				rcv_fast = ($urandom_range(0, 2) == 0);
			stall_draw = rcv_fast ? 0 : $urandom_range(0, 19);
			stall_left <= stall_draw;
			out_ready  <= (stall_draw == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= (stall_left == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Timeout
	initial begin
		#10000000;
		$display("particle_pair_delta_r_top: mismatch");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		int          n_words;
		int          ev_len;
		int          sel;
		int          kind;
		int unsigned gap;
		bit          send_fast;
		longint      p;
		longint      e;
		longint      f;
		bit          l;

		// no kind stored yet: everything still at the reset zeros
		add_word(100, 1234, -777, 1'b1, $urandom_range(0, 19));
		// ignored ids at the pid extremes and next to the real codes
		add_word(8388607, 32767, 8191, 1'b0, $urandom_range(0, 19));
		add_word(-8388608, -32768, -8192, 1'b0, $urandom_range(0, 19));
		add_word(0, 5, 5, 1'b0, 0);
		add_word(-1, 0, 0, 1'b0, 0);
		add_word(24, 11, 11, 1'b0, 0);
		add_word(-25, 22, 22, 1'b1, $urandom_range(0, 19));
		// largest eta distance saturates
		add_word(25, 32767, 8191, 1'b0, 0);
		add_word(28, -32768, -8192, 1'b1, $urandom_range(0, 19));
		// phi difference exactly pi wraps, minus pi stays
		add_word(5, 100, 6434, 1'b0, 0);
		add_word(-5, -100, 0, 1'b1, 0);
		add_word(5, 0, -6434, 1'b0, 0);
		add_word(-5, 0, 0, 1'b1, $urandom_range(0, 19));
		// phi more than two pi apart comes back inside after one correction
		add_word(5, -32768, 8191, 1'b0, 0);
		add_word(-5, 32767, -8192, 1'b1, 0);
		// root itself above the top value saturates
		add_word(25, 32767, 3200, 1'b0, 0);
		add_word(28, -32533, -3200, 1'b1, $urandom_range(0, 19));
		// same kind twice in one event: the later one wins
		add_word(25, 4000, 1000, 1'b0, 0);
		add_word(28, -4000, -1000, 1'b0, 0);
		add_word(25, 1000, -500, 1'b0, 0);
		add_word(7, 999, 999, 1'b1, 0);
		// back to back event ends with no gaps
		add_word(-5, 2048, 4096, 1'b1, 0);
		add_word(5, -2048, -4096, 1'b1, 0);
		add_word(28, 0, 6433, 1'b1, $urandom_range(0, 19), 1'b1);

		// random events, mostly the tracked kinds
		n_words   = 0;
		send_fast = 1'b0;
		while (n_words < N_RANDOM) begin
			ev_len = $urandom_range(1, 8);
			for (int i = 0; i < ev_len; i++) begin
				if (n_words % 150 == 0)
					send_fast = ($urandom_range(0, 2) == 0);
				sel = $urandom_range(0, 9);
				kind = $urandom_range(0, 3);
				p = (kind == 0) ? 25 : (kind == 1) ? 28 : (kind == 2) ? 5 : -5;
				if (sel == 7)
					p = longint'($urandom());
				else if (sel == 8)
					p = p + (($urandom_range(0, 1) == 0) ? 1 : -1);
				e = ($urandom_range(0, 1) == 0) ? longint'($urandom()) :
					longint'($urandom_range(0, 8192)) - 4096;
				f = ($urandom_range(0, 4) == 0) ? longint'($urandom()) :
					longint'($urandom_range(0, 12868)) - 6434;
				// drop the event end now and then to merge events
				l = (i == ev_len - 1) && ($urandom_range(0, 19) != 0);
				gap = send_fast ? 0 : $urandom_range(0, 19);
				add_word(p, e, f, l, gap, (n_words == 800) || ($urandom_range(0, 299) == 0));
				n_words++;
			end
		end
		add_word(25, 0, 0, 1'b1, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_dr.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("particle_pair_delta_r_top: match");
		else
			$display("particle_pair_delta_r_top: mismatch");
		$finish;
	end

endmodule
